// ----- design/tone_sequence_player_defines.svh -----
// ----------------------------------------------------------------------------
// tone_sequence_player_defines
// Assertion macros shared by the tone sequence player. They expect signals
// named clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef TONE_SEQUENCE_PLAYER_DEFINES_SVH
`define TONE_SEQUENCE_PLAYER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TSP_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("tone_sequence_player: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define TSP_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("tone_sequence_player: next-cycle check failed");

`endif

// ----- design/tsp_pkg.sv -----
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the tone sequence player.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsp_pkg;

  // Defaults for the top-level parameters
  localparam int FIFO_DEPTH_DEF = 4096;
  localparam int TICK_RATE_DEF  = 1193182;

  // Bytes in one tone record: frequency low/high, duration low/high
  localparam int REC_BYTES = 4;

  // Field widths fixed by the interface
  localparam int THR_W   = 13;
  localparam int LEVEL_W = 13;
  localparam int DIV_W   = 16;

  localparam logic [THR_W-1:0] WAKE_THRESHOLD_RST = 13'd4096;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;

  // Input opcodes as they arrive on the stream
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_MUTE  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // Command kinds handed to the back end
  typedef enum logic [3:0] {
    CMD_PUSH  = 4'b0001,
    CMD_TICK  = 4'b0010,
    CMD_MUTE  = 4'b0100,
    CMD_FLUSH = 4'b1000
  } tsp_kind_t;

  typedef struct packed {
    tsp_kind_t  kind;
    logic [7:0] data;
  } tsp_cmd_t;

  // Result word, last member in the lowest bits
  typedef struct packed {
    logic               drained;
    logic               space_wake;
    logic [LEVEL_W-1:0] fifo_level;
    logic               playing;
    logic               divider_load;
    logic [DIV_W-1:0]   divider;
    logic               gate_on;
    logic               byte_accepted;
  } tsp_result_t;

  localparam int OUT_TDATA_W = 40;

endpackage

// ----- design/tone_sequence_player.sv -----
// ----------------------------------------------------------------------------
// tone_sequence_player
// Byte FIFO fed tone sequencer driving a square wave divider and speaker gate.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tuser opcode, tdata data_byte
//  m_*       out  m_tvalid/m_tready    tdata result word
//  cfg_*     in   cfg_valid/cfg_ready  cfg_data wake_threshold
//
//  Words are handled one at a time: the next is accepted only once the
//  result of the last has been handed off, and a tone record start also
//  waits on the one-bit-per-cycle divider. Reset is synchronous; the byte
//  store is not cleared. The input queues up to four words while a result
//  waits on m_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tone_sequence_player_defines.svh"

module tone_sequence_player #(
  parameter int FIFO_DEPTH = tsp_pkg::FIFO_DEPTH_DEF,
  parameter int TICK_RATE  = tsp_pkg::TICK_RATE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // byte_accepted[0], gate_on[1], divider[17:2],
                                 // divider_load[18], playing[19],
                                 // fifo_level[32:20], space_wake[33],
                                 // drained[34], zero[39:35]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data   // wake_threshold[12:0]
);
  import tsp_pkg::*;

  tsp_cmd_t         f_cmd;
  logic             f_valid;
  logic             f_ready;
  tsp_cmd_t         q_cmd;
  logic             q_valid;
  logic             q_ready;
  tsp_result_t      res;
  logic [THR_W-1:0] wake_threshold;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_threshold <= WAKE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      wake_threshold <= cfg_data;
    end
  end

  tsp_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  tsp_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  tsp_engine #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .TICK_RATE  (TICK_RATE)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (q_valid),
    .cmd_ready      (q_ready),
    .cmd            (q_cmd),
    .wake_threshold (wake_threshold),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res            (res)
  );

  // Pack the result word, zero padded to whole bytes
  assign m_tdata = {{(OUT_TDATA_W - $bits(tsp_result_t)){1'b0}}, res};

  // Drained means stopped, gate closed and the empty FIFO raising space wake
  `TSP_ASSERT_IMPL(a_drain_stops, m_tvalid && res.drained, !res.playing && !res.gate_on)
  `TSP_ASSERT_IMPL(a_drain_wakes, m_tvalid && res.drained, res.space_wake)
  // A divider load only comes with a record being timed
  `TSP_ASSERT_IMPL(a_load_plays, m_tvalid && res.divider_load, res.playing)
  // The single result slot is empty in the cycle after a handoff
  `TSP_ASSERT_NEXT(a_slot_gap, m_tvalid && m_tready, !m_tvalid)

endmodule

// ----- design/tsp_front.sv -----
// ----------------------------------------------------------------------------
// tsp_front
// Input side: takes stream words and classifies them into commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_front (
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte[7:0]
  input  logic [1:0]         s_tuser,   // opcode[1:0]
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output tsp_pkg::tsp_cmd_t  cmd
);
  import tsp_pkg::*;

  // Pass the handshake through to the queue
  assign cmd_valid = s_tvalid;
  assign s_tready  = cmd_ready;

  // Decode the opcode into a command kind
  always_comb begin
    cmd.data = s_tdata;
    unique case (s_tuser)
      OP_PUSH:  cmd.kind = CMD_PUSH;
      OP_TICK:  cmd.kind = CMD_TICK;
      OP_MUTE:  cmd.kind = CMD_MUTE;
      default:  cmd.kind = CMD_FLUSH;
    endcase
  end

endmodule

// ----- design/tsp_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// tsp_cmd_queue
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  tsp_pkg::tsp_cmd_t  push_cmd,
  output logic               pop_valid,
  input  logic               pop_ready,
  output tsp_pkg::tsp_cmd_t  pop_cmd
);
  import tsp_pkg::*;

  localparam int QAW = $clog2(CMDQ_DEPTH);
  localparam int QCW = $clog2(CMDQ_DEPTH + 1);

  tsp_cmd_t       slots [CMDQ_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill != QCW'(CMDQ_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- design/tsp_div.sv -----
// ----------------------------------------------------------------------------
// tsp_div
// Restoring divider: constant tick rate over a 16-bit frequency, one
// quotient bit per cycle, low 16 quotient bits kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_div #(
  parameter int TICK_RATE = tsp_pkg::TICK_RATE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tsp_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [tsp_pkg::DIV_W-1:0] quotient
);
  import tsp_pkg::*;

  localparam int DW  = $clog2(TICK_RATE + 1);
  localparam int CNW = $clog2(DW + 1);
  localparam logic [DW-1:0] DVD = DW'(TICK_RATE);

  logic             busy;
  logic [CNW-1:0]   cnt;
  logic [DW-1:0]    dvd_sh;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, dvd_sh[DW-1]};
  assign fits   = (rem_sh >= {1'b0, dsr});

  // Control: busy flag, step count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_sh   <= DVD;
      rem      <= '0;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      dvd_sh   <= dvd_sh << 1;
      rem      <= fits ? DIV_W'(rem_sh - {1'b0, dsr}) : DIV_W'(rem_sh);
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

// ----- design/tsp_engine.sv -----
// ----------------------------------------------------------------------------
// tsp_engine
// Back end: byte FIFO, record fetch, tone timing and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_engine #(
  parameter int FIFO_DEPTH = tsp_pkg::FIFO_DEPTH_DEF,
  parameter int TICK_RATE  = tsp_pkg::TICK_RATE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  tsp_pkg::tsp_cmd_t          cmd,
  input  logic [tsp_pkg::THR_W-1:0]  wake_threshold,
  output logic                       res_valid,
  input  logic                       res_ready,
  output tsp_pkg::tsp_result_t       res
);
  import tsp_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int SW = CW + 1;
  localparam int WW = (CW > THR_W) ? CW : THR_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_CHECK  = 8'b00000010,
    S_FETCH  = 8'b00000100,
    S_DECODE = 8'b00001000,
    S_DIV    = 8'b00010000,
    S_FINISH = 8'b00100000,
    S_EMIT   = 8'b01000000,
    S_SPARE  = 8'b10000000
  } state_t;

  state_t           state;
  state_t           idle_next;
  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rd_data;
  logic [7:0]       rec [REC_BYTES];
  logic [1:0]       bidx;

  logic [CW-1:0]    count;
  logic [PW-1:0]    rp;
  logic [15:0]      ms;
  logic             active;
  logic             mute;
  logic             flush_pend;
  logic             gate;
  logic [DIV_W-1:0] divider;

  logic             acc;
  logic             load;
  logic             expiry;
  logic             drn;
  logic             flush_apply;

  logic             take;
  logic             tick_exp;
  logic             wr_en;
  logic             rd_en;
  logic [SW-1:0]    wsum;
  logic [SW-1:0]    wadj;
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp_next;
  logic             has_room;
  logic             has_record;
  logic [CW-1:0]    free_cnt;
  logic             wake;
  logic [DIV_W-1:0] freq;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  assign cmd_ready  = (state == S_IDLE) && !res_valid;
  assign take       = cmd_valid && cmd_ready;
  assign has_room   = (count < CW'(FIFO_DEPTH));
  assign has_record = (count >= CW'(REC_BYTES));
  assign freq       = {rec[1], rec[0]};

  // Tick that ends the current record, and where an accepted word goes next
  assign tick_exp  = (cmd.kind == CMD_TICK) && active && (ms <= 16'd1);
  assign idle_next = (((cmd.kind == CMD_PUSH) && !active) || (tick_exp && (count != '0)))
                     ? S_CHECK : S_EMIT;

  // Write address: read pointer plus fill, wrapped once
  assign wsum = SW'(rp) + SW'(count);
  assign wadj = (wsum >= SW'(FIFO_DEPTH)) ? wsum - SW'(FIFO_DEPTH) : wsum;
  assign wp   = PW'(wadj);
  assign rp_next = (rp == PW'(FIFO_DEPTH - 1)) ? '0 : rp + 1'b1;

  assign wr_en = take && (cmd.kind == CMD_PUSH) && has_room;
  assign rd_en = ((state == S_CHECK) && has_record) ||
                 ((state == S_FETCH) && (bidx != 2'd3));

  assign div_start = (state == S_DECODE) && (freq != '0);

  // Space wake on a record expiry: free bytes against threshold, or an empty FIFO
  assign free_cnt = CW'(FIFO_DEPTH) - count;
  assign wake = expiry && ((WW'(free_cnt) >= WW'(wake_threshold)) || (count == '0));

  tsp_div #(
    .TICK_RATE (TICK_RATE)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (freq),
    .done     (div_done),
    .quotient (div_q)
  );

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= cmd.data;
    end
    if (rd_en) begin
      rd_data <= mem[rp];
    end
  end

  // Sequence one command at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rp         <= '0;
      ms         <= '0;
      active     <= 1'b0;
      mute       <= 1'b0;
      flush_pend <= 1'b0;
      gate       <= 1'b0;
      divider    <= '0;
      res_valid  <= 1'b0;
      bidx       <= '0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            acc         <= (cmd.kind == CMD_PUSH) && has_room;
            load        <= 1'b0;
            expiry      <= tick_exp;
            drn         <= tick_exp && (count == '0);
            flush_apply <= tick_exp && (count != '0);
            state       <= idle_next;
            unique case (cmd.kind)
              CMD_PUSH: begin
                if (has_room) begin
                  count <= count + 1'b1;
                end
              end
              CMD_TICK: begin
                if (active) begin
                  if (ms > 16'd1) begin
                    ms <= ms - 1'b1;
                  end else begin
                    ms <= '0;
                    if (count == '0) begin
                      active <= 1'b0;
                      gate   <= 1'b0;
                    end
                  end
                end
              end
              CMD_MUTE: begin
                mute <= cmd.data[0];
                if (cmd.data[0]) begin
                  gate <= 1'b0;
                end
              end
              CMD_FLUSH: begin
                flush_pend <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        // Start a record if four bytes are held, else stop play
        S_CHECK: begin
          if (has_record) begin
            count <= count - 1'b1;
            rp    <= rp_next;
            bidx  <= '0;
            state <= S_FETCH;
          end else begin
            active <= 1'b0;
            gate   <= 1'b0;
            state  <= S_FINISH;
          end
        end
        // Collect the record bytes as the reads return
        S_FETCH: begin
          rec[bidx] <= rd_data;
          if (bidx == 2'd3) begin
            state <= S_DECODE;
          end else begin
            count <= count - 1'b1;
            rp    <= rp_next;
            bidx  <= bidx + 1'b1;
          end
        end
        // Load the duration; silence closes the gate
        S_DECODE: begin
          active <= 1'b1;
          ms     <= {rec[3], rec[2]};
          if (freq == '0) begin
            gate  <= 1'b0;
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            divider <= div_q;
            load    <= 1'b1;
            if (!mute) begin
              gate <= 1'b1;
            end
            state <= S_FINISH;
          end
        end
        // Drop the rest of the FIFO after a flushed expiry
        S_FINISH: begin
          if (flush_apply && flush_pend) begin
            count      <= '0;
            rp         <= '0;
            flush_pend <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          res.byte_accepted <= acc;
          res.gate_on       <= gate;
          res.divider       <= divider;
          res.divider_load  <= load;
          res.playing       <= active;
          res.fifo_level    <= LEVEL_W'(count);
          res.space_wake    <= wake;
          res.drained       <= drn;
          res_valid         <= 1'b1;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
